// ===== sv/coded_block_receive_window_assert.svh =====
// Assertion macros used by the checker file
`ifndef CODED_BLOCK_RECEIVE_WINDOW_ASSERT_SVH
`define CODED_BLOCK_RECEIVE_WINDOW_ASSERT_SVH

// same-cycle implication
`define CBRW_ASSERT_IMP(label, ck, rn, a, c) \
	label: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("cbrw: same-cycle check failed");

// next-cycle implication
`define CBRW_ASSERT_NXT(label, ck, rn, a, c) \
	label: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("cbrw: next-cycle check failed");

`endif

// ===== sv/cbrw_pkg.sv =====
package cbrw_pkg;

	localparam int SLOTS     = 16;
	localparam int SLOT_W    = 4;
	localparam int SHARDS    = 16;
	localparam int SHARD_W   = 4;
	localparam int MAX_STEPS = 32;

	localparam logic [4:0]  DEF_WINDOW  = 5'd16;
	localparam logic [4:0]  DEF_SHARDS  = 5'd4;
	localparam logic [30:0] DEF_TIMEOUT = 31'd50000;

	// register indexes (word address)
	localparam logic [1:0] REG_WINDOW  = 2'd0;
	localparam logic [1:0] REG_SHARDS  = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_CHECK   = 2'd1,
		CMD_MARK    = 2'd2,
		CMD_ADVANCE = 2'd3
	} command_t;

	typedef enum logic [3:0] {
		ST_STORED   = 4'd0,
		ST_NOSLOT   = 4'd1,
		ST_DECODED  = 4'd2,
		ST_BADIDX   = 4'd3,
		ST_DUP      = 4'd4,
		ST_NOTREADY = 4'd5,
		ST_READY    = 4'd6,
		ST_MARKED   = 4'd7,
		ST_ADVANCED = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_ADD,
		OP_MARK,
		OP_CLEAR
	} tbl_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_RESOLVE,
		S_ADV_SCAN,
		S_ADV_CLEAR,
		S_ADV_DONE
	} state_t;

	// slot table write request
	typedef struct packed {
		tbl_op_t             op;
		logic [SLOT_W-1:0]   idx;
		logic [31:0]         block;
		logic [SHARD_W-1:0]  shard;
		logic [31:0]         stamp;
	} tbl_wr_t;

	// slot table compare results for the addressed slot
	typedef struct packed {
		logic               occ;
		logic               eq;
		logic               newer;
		logic               done;
		logic               expired;
		logic [4:0]         count;
		logic [SHARDS-1:0]  map;
	} tbl_rd_t;

endpackage

// ===== sv/cbrw_if.sv =====
// command channel
interface cbrw_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] block_num;
	logic [7:0]  shard_pos;
	logic [31:0] now_time;

	modport source (output valid, command, block_num, shard_pos, now_time, input ready);
	modport sink   (input valid, command, block_num, shard_pos, now_time, output ready);
endinterface

// result channel
interface cbrw_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [3:0]  slot_index;
	logic [4:0]  shard_count;
	logic [15:0] received_map;
	logic [31:0] base_block;
	logic [5:0]  advanced;

	modport source (output valid, status, slot_index, shard_count, received_map,
		base_block, advanced, input ready);
	modport sink   (input valid, status, slot_index, shard_count, received_map,
		base_block, advanced, output ready);
endinterface

// ===== sv/cbrw_slot_table.sv =====
module cbrw_slot_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [cbrw_pkg::SLOT_W-1:0] rd_idx,
	input  logic [31:0]                 key,
	input  logic [31:0]                 base,
	input  logic [31:0]                 now,
	input  logic [30:0]                 timeout,
	input  cbrw_pkg::tbl_wr_t           wr,
	output cbrw_pkg::tbl_rd_t           rd
);
	import cbrw_pkg::*;

	logic [31:0]       block_q [SLOTS];
	logic [31:0]       first_q [SLOTS];
	logic [4:0]        count_q [SLOTS];
	logic [SHARDS-1:0] map_q   [SLOTS];
	logic [SLOTS-1:0]  done_q;

	logic [31:0] diff;
	logic [31:0] age;

	// shared compare unit on the addressed slot
	always_comb begin
		diff       = block_q[rd_idx] - base;
		age        = now - first_q[rd_idx];
		rd.occ     = count_q[rd_idx] != 5'd0;
		rd.eq      = rd.occ && (block_q[rd_idx] == key);
		rd.newer   = rd.occ && !diff[31] && (diff != 32'd0);
		rd.done    = done_q[rd_idx];
		rd.expired = !age[31] && (age[30:0] >= timeout);
		rd.count   = count_q[rd_idx];
		rd.map     = map_q[rd_idx];
	end

	// payload: block number and first arrival
	always_ff @(posedge clk) begin
		if (wr.op == OP_ADD && count_q[wr.idx] == 5'd0) begin
			block_q[wr.idx] <= wr.block;
			first_q[wr.idx] <= wr.stamp;
		end
	end

	// occupancy, bitmap, decoded flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				count_q[i] <= '0;
				map_q[i]   <= '0;
			end
			done_q <= '0;
		end else begin
			case (wr.op)
				OP_ADD: begin
					map_q[wr.idx]   <= map_q[wr.idx] | (SHARDS'(1) << wr.shard);
					count_q[wr.idx] <= count_q[wr.idx] + 5'd1;
				end
				OP_MARK: begin
					done_q[wr.idx] <= 1'b1;
				end
				OP_CLEAR: begin
					count_q[wr.idx] <= '0;
					map_q[wr.idx]   <= '0;
					done_q[wr.idx]  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/cbrw_ctrl.sv =====
module cbrw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [4:0]           win_cfg,
	input  logic [4:0]           data_shards,
	cbrw_req_if.sink             req,
	cbrw_rsp_if.source           rsp,
	input  cbrw_pkg::tbl_rd_t    rd,
	output logic [cbrw_pkg::SLOT_W-1:0] rd_idx,
	output logic [31:0]          key,
	output logic [31:0]          base,
	output logic [31:0]          now,
	output cbrw_pkg::tbl_wr_t    wr
);
	import cbrw_pkg::*;

	state_t state_q, state_d;

	command_t          cmd_q;
	logic [31:0]       id_q;
	logic [7:0]        shard_q;
	logic [31:0]       now_q;
	logic [31:0]       base_q;
	logic [4:0]        scan_q;
	logic [5:0]        moved_q;
	logic              match_q, free_q;
	logic [SLOT_W-1:0] match_idx_q, free_idx_q;
	logic              bmf_q, bmgo_q, newer_q;

	logic              rsp_valid_q;
	logic [3:0]        rsp_status_q;
	logic [3:0]        rsp_idx_q;
	logic [4:0]        rsp_cnt_q;
	logic [15:0]       rsp_map_q;
	logic [31:0]       rsp_base_q;
	logic [5:0]        rsp_moved_q;

	logic [4:0]        ws, k;
	logic [31:0]       req_diff;
	logic              in_win, accept, out_busy, last_ws, last_all;
	logic              hit, bmf_n, bmgo_n, newer_n, go;
	logic [SLOT_W-1:0] sel;
	logic              load;
	status_t           st;
	logic [3:0]        o_idx;
	logic [4:0]        o_cnt;
	logic [15:0]       o_map;

	// window and threshold
	always_comb begin
		ws       = (win_cfg > 5'(SLOTS)) ? 5'(SLOTS) : win_cfg;
		k        = (data_shards == 5'd0) ? 5'd1 : data_shards;
		req_diff = req.block_num - base_q;
		in_win   = !req_diff[31] && (req_diff[30:5] == '0) && (req_diff[4:0] < ws);
		accept   = req.valid && req.ready;
		out_busy = rsp_valid_q && !rsp.ready;
		last_ws  = scan_q == (ws - 5'd1);
		last_all = scan_q == 5'(SLOTS - 1);
		hit      = match_q || free_q;
		sel      = match_q ? match_idx_q : free_idx_q;
		bmf_n    = bmf_q || rd.eq;
		bmgo_n   = bmf_q ? bmgo_q : (rd.eq && (rd.done || rd.expired));
		newer_n  = newer_q || rd.newer;
		go       = (bmf_n && bmgo_n) || newer_n;
	end

	assign req.ready = state_q == S_IDLE;
	assign rd_idx    = (state_q == S_RESOLVE) ? sel : scan_q[SLOT_W-1:0];
	assign key       = (state_q == S_LOOK) ? id_q : base_q;
	assign base      = base_q;
	assign now       = now_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, table writes, result values
	always_comb begin
		state_d  = state_q;
		wr       = '0;
		wr.op    = OP_NONE;
		wr.idx   = sel;
		wr.block = id_q;
		wr.shard = shard_q[SHARD_W-1:0];
		wr.stamp = now_q;
		load     = 1'b0;
		st       = ST_NOSLOT;
		o_idx    = '0;
		o_cnt    = '0;
		o_map    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (command_t'(req.command) == CMD_ADVANCE) begin
						state_d = (ws == 5'd0) ? S_ADV_DONE : S_ADV_SCAN;
					end else begin
						state_d = in_win ? S_LOOK : S_RESOLVE;
					end
				end
			end
			S_LOOK: begin
				if (last_ws) state_d = S_RESOLVE;
			end
			S_RESOLVE: begin
				if (hit) begin
					o_idx = 4'(sel);
					o_cnt = rd.count;
					o_map = rd.map;
					if (rd.done) begin
						st = ST_DECODED;
					end else if (cmd_q == CMD_INSERT) begin
						if (shard_q >= 8'(SHARDS)) begin
							st = ST_BADIDX;
						end else if (rd.map[shard_q[SHARD_W-1:0]]) begin
							st = ST_DUP;
						end else begin
							st    = ST_STORED;
							o_cnt = rd.count + 5'd1;
							o_map = rd.map | (SHARDS'(1) << shard_q[SHARD_W-1:0]);
							if (!out_busy) wr.op = OP_ADD;
						end
					end else if (rd.count < k) begin
						st = ST_NOTREADY;
					end else if (cmd_q == CMD_CHECK) begin
						st = ST_READY;
					end else begin
						st = ST_MARKED;
						if (!out_busy) wr.op = OP_MARK;
					end
				end
				if (!out_busy) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_ADV_SCAN: begin
				if (last_ws) state_d = go ? S_ADV_CLEAR : S_ADV_DONE;
			end
			S_ADV_CLEAR: begin
				if (rd.eq) begin
					wr.op  = OP_CLEAR;
					wr.idx = scan_q[SLOT_W-1:0];
				end
				if (last_all) begin
					state_d = (moved_q == 6'(MAX_STEPS - 1)) ? S_ADV_DONE : S_ADV_SCAN;
				end
			end
			S_ADV_DONE: begin
				st = ST_ADVANCED;
				if (!out_busy) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// command beat and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			scan_q  <= '0;
			moved_q <= '0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			bmf_q   <= 1'b0;
			bmgo_q  <= 1'b0;
			newer_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					scan_q  <= '0;
					moved_q <= '0;
					match_q <= 1'b0;
					free_q  <= 1'b0;
					bmf_q   <= 1'b0;
					bmgo_q  <= 1'b0;
					newer_q <= 1'b0;
				end
				S_LOOK: begin
					scan_q <= scan_q + 5'd1;
					if (rd.eq && !match_q) begin
						match_q     <= 1'b1;
						match_idx_q <= scan_q[SLOT_W-1:0];
					end
					if (!rd.occ && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= scan_q[SLOT_W-1:0];
					end
				end
				S_ADV_SCAN: begin
					bmf_q   <= bmf_n;
					bmgo_q  <= bmgo_n;
					newer_q <= newer_n;
					scan_q  <= last_ws ? 5'd0 : scan_q + 5'd1;
				end
				S_ADV_CLEAR: begin
					scan_q <= last_all ? 5'd0 : scan_q + 5'd1;
					if (last_all) begin
						base_q  <= base_q + 32'd1;
						moved_q <= moved_q + 6'd1;
						bmf_q   <= 1'b0;
						bmgo_q  <= 1'b0;
						newer_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// latched command payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command_t'(req.command);
			id_q    <= req.block_num;
			shard_q <= req.shard_pos;
			now_q   <= req.now_time;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// base is captured with the beat so a later advance cannot disturb it
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_status_q <= st;
			rsp_idx_q    <= o_idx;
			rsp_cnt_q    <= o_cnt;
			rsp_map_q    <= o_map;
			rsp_base_q   <= base_q;
			rsp_moved_q  <= (state_q == S_ADV_DONE) ? moved_q : 6'd0;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.slot_index   = rsp_idx_q;
	assign rsp.shard_count  = rsp_cnt_q;
	assign rsp.received_map = rsp_map_q;
	assign rsp.base_block   = rsp_base_q;
	assign rsp.advanced     = rsp_moved_q;

endmodule

// ===== sv/coded_block_receive_window.sv =====
// Channel  Dir  Beat contents
// req      in   command, block_num, shard_pos, now_time
// rsp      out  status, slot_index, shard_count, received_map, base_block, advanced
// apb      in   window @0x0, data_shards @0x4, timeout_us @0x8
//
// Insert, check, mark: a look pass over W slots (W = window size capped at 16; none
// out of window), one slot per cycle through the single table read port and its
// compare unit, then resolve. Advance: per base step a scan of W slots, then a full
// clear pass of all 16 slots; the closing scan is dropped when the steps reach 32.
// Reset leaves the table empty and base at zero; ready straight out of reset.
// A stalled result holds; the next command is taken while it waits.
module coded_block_receive_window (
	input  logic        clk,
	input  logic        arst_n,
	cbrw_req_if.sink    req,
	cbrw_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cbrw_pkg::*;

	logic [4:0]  window_q;
	logic [4:0]  shards_q;
	logic [30:0] timeout_q;

	logic [SLOT_W-1:0] rd_idx;
	logic [31:0]       key, base, now;
	tbl_wr_t           wr;
	tbl_rd_t           rd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= DEF_WINDOW;
			shards_q  <= DEF_SHARDS;
			timeout_q <= DEF_TIMEOUT;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_WINDOW:  window_q  <= pwdata[4:0];
				REG_SHARDS:  shards_q  <= pwdata[4:0];
				REG_TIMEOUT: timeout_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WINDOW:  prdata = {27'd0, window_q};
			REG_SHARDS:  prdata = {27'd0, shards_q};
			REG_TIMEOUT: prdata = {1'b0, timeout_q};
			default:     prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	cbrw_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.win_cfg     (window_q),
		.data_shards (shards_q),
		.req         (req),
		.rsp         (rsp),
		.rd          (rd),
		.rd_idx      (rd_idx),
		.key         (key),
		.base        (base),
		.now         (now),
		.wr          (wr)
	);

	cbrw_slot_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (rd_idx),
		.key     (key),
		.base    (base),
		.now     (now),
		.timeout (timeout_q),
		.wr      (wr),
		.rd      (rd)
	);

endmodule

// ===== sv/cbrw_checker.sv =====
`include "coded_block_receive_window_assert.svh"

module cbrw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [3:0]  rsp_status,
	input logic [3:0]  rsp_slot_index,
	input logic [4:0]  rsp_shard_count,
	input logic [5:0]  rsp_advanced
);
	import cbrw_pkg::*;

	// a waiting result stays up
	`CBRW_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// one command at a time: busy right after an accept
	`CBRW_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)

	// only defined status codes leave the block
	`CBRW_ASSERT_IMP(a_status_range, clk, arst_n, rsp_valid, rsp_status <= ST_ADVANCED)

	// moved count only on advance
	`CBRW_ASSERT_IMP(a_moved_only_adv, clk, arst_n, rsp_valid && rsp_status != ST_ADVANCED, rsp_advanced == 6'd0)

	// no slot or an advance means zeroed slot fields
	`CBRW_ASSERT_IMP(a_noslot_zero, clk, arst_n, rsp_valid && (rsp_status == ST_NOSLOT || rsp_status == ST_ADVANCED), rsp_slot_index == 4'd0 && rsp_shard_count == 5'd0)

endmodule

bind coded_block_receive_window cbrw_checker u_cbrw_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_slot_index  (rsp.slot_index),
	.rsp_shard_count (rsp.shard_count),
	.rsp_advanced    (rsp.advanced)
);
